// ----- design/swm_pkg.sv -----
// Shared constants and word types for the sliding window maximum filter.
package swm_pkg;

  localparam int MAX_WINDOW  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_BITS    = 7;
  localparam int WIN_BITS    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
  localparam int CMP_BITS    = (CFG_BITS > CNT_BITS) ? CFG_BITS : CNT_BITS;
  localparam int CFG_RESET   = 3;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    sample_t sample;
    logic    last_sample;
  } in_word_t;

  typedef struct packed {
    sample_t window_max;
    logic    last_result;
  } out_word_t;

  // Running maximum that walks down the chain
  typedef struct packed {
    logic    vld;
    sample_t max;
  } tok_t;

  // Controls shared by every cell
  typedef struct packed {
    logic shift;
    logic adv;
  } cell_ctrl_t;

endpackage

// ----- design/swm_cell.sv -----
// One cell of the history chain: a stored sample and a stage of the running maximum.
module swm_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  swm_pkg::cell_ctrl_t ctrl_i,
  input  logic               start_i,
  input  swm_pkg::sample_t   sample_i,
  output swm_pkg::sample_t   sample_o,
  input  swm_pkg::tok_t      tok_i,
  output swm_pkg::tok_t      tok_o
);
  import swm_pkg::*;

  sample_t sample_q;
  logic    tok_vld_q;
  sample_t tok_max_q;
  tok_t    tok_q, tok_d;

  assign tok_q = '{vld: tok_vld_q, max: tok_max_q};

  // Shift the history one cell on each accepted word
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      sample_q <= sample_i;
    end
  end

  // Inject a fresh maximum here, or fold this sample into the one passing by
  always_comb begin
    tok_d = tok_q;
    if (ctrl_i.adv) begin
      if (start_i) begin
        tok_d.vld = 1'b1;
        tok_d.max = sample_q;
      end else if (tok_i.vld) begin
        tok_d.vld = 1'b1;
        tok_d.max = ($signed(tok_i.max) > $signed(sample_q)) ? tok_i.max : sample_q;
      end else begin
        tok_d.vld = 1'b0;
        tok_d.max = tok_i.max;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_d.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_max_q <= tok_d.max;
  end

  assign sample_o = sample_q;
  assign tok_o    = tok_q;

endmodule

// ----- design/swm_chain.sv -----
// Row of history cells; samples move up the row, the running maximum moves down.
module swm_chain (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  swm_pkg::cell_ctrl_t            ctrl_i,
  input  logic [swm_pkg::MAX_WINDOW-1:0] start_i,
  input  swm_pkg::sample_t               sample_i,
  output swm_pkg::tok_t                  tok0_o,
  output logic [swm_pkg::MAX_WINDOW-1:0] tok_vld_o
);
  import swm_pkg::*;

  sample_t samp [MAX_WINDOW];
  tok_t    tok  [MAX_WINDOW];

  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    sample_t samp_in;
    tok_t    tok_in;

    // Newest sample enters cell zero; the far end sees no incoming maximum
    if (k == 0) begin : g_head
      assign samp_in = sample_i;
    end else begin : g_body
      assign samp_in = samp[k-1];
    end
    if (k == MAX_WINDOW - 1) begin : g_tail
      assign tok_in = '0;
    end else begin : g_link
      assign tok_in = tok[k+1];
    end

    swm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl_i),
      .start_i  (start_i[k]),
      .sample_i (samp_in),
      .sample_o (samp[k]),
      .tok_i    (tok_in),
      .tok_o    (tok[k])
    );

    assign tok_vld_o[k] = tok[k].vld;
  end

  assign tok0_o = tok[0];

endmodule

// ----- design/sliding_window_maximum.sv -----
// Top level of the sliding window maximum filter: control, fill count and output register.
//
//   channel  direction  handshake                  word
//   in       input      in_valid_i / in_stall_o    in_word_i  (sample, last_sample)
//   out      output     out_valid_o / out_stall_i  out_word_o (window_max, last_result)
//   cfg      input      cfg_we_i                   cfg_wdata_i (window_size)
//
// A word that yields a result holds the input stalled (w = effective window, 1..MAX_WINDOW):
// the running maximum enters the chain at cell w-1 and walks one cell per cycle to cell 0.
// A word that yields no result leaves the input unstalled. The history clearing after a last word
// is only a fill count reset, with no clearing pass. Reset clears control state and sets
// window_size to 3. A stalled output holds the finished maximum at cell 0; input words
// are taken again once the result sits in the output register.
module sliding_window_maximum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  swm_pkg::in_word_t            in_word_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output swm_pkg::out_word_t           out_word_o,
  input  logic                         cfg_we_i,
  input  logic [swm_pkg::CFG_BITS-1:0] cfg_wdata_i
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_START = 3'b010,
    ST_RUN   = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [CFG_BITS-1:0]   cfg_q;
  logic [CNT_BITS-1:0]   fill_q, fill_d, fill_inc;
  logic [CMP_BITS-1:0]   win_raw, win_eff;
  logic [WIN_BITS-1:0]   win_idx;
  logic                  last_q;
  logic                  in_acc, produce, out_free, res_load;
  logic                  out_vld_q;
  out_word_t             out_q;
  cell_ctrl_t            ctrl;
  logic [MAX_WINDOW-1:0] start_vec, tok_vld;
  tok_t                  tok0;

  // Hold the window size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_BITS'(CFG_RESET);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Clamp the window to 1..MAX_WINDOW
  always_comb begin
    win_raw = CMP_BITS'(cfg_q);
    priority if (win_raw == '0) begin
      win_eff = CMP_BITS'(1);
    end else if (win_raw > CMP_BITS'(MAX_WINDOW)) begin
      win_eff = CMP_BITS'(MAX_WINDOW);
    end else begin
      win_eff = win_raw;
    end
  end
  assign win_idx = WIN_BITS'(win_eff - CMP_BITS'(1));

  // Count samples of the current sequence, saturating at the chain length
  assign in_acc   = in_valid_i && !in_stall_o;
  assign fill_inc = (fill_q == CNT_BITS'(MAX_WINDOW)) ? fill_q : fill_q + CNT_BITS'(1);
  assign produce  = CMP_BITS'(fill_inc) >= win_eff;
  assign fill_d   = in_word_i.last_sample ? '0 : fill_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (in_acc) begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      last_q <= in_word_i.last_sample;
    end
  end

  // Sequence one word: accept, inject, walk the maximum down to cell zero
  assign out_free = !out_vld_q || !out_stall_i;
  assign res_load = (state_q == ST_RUN) && tok0.vld && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && produce) state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Drive the chain: shift on accept, freeze the walk while the output is blocked
  assign ctrl = '{shift: in_acc,
                  adv:   !((state_q == ST_RUN) && tok0.vld && !out_free)};

  always_comb begin
    for (int k = 0; k < MAX_WINDOW; k++) begin
      start_vec[k] = (state_q == ST_START) && (win_idx == WIN_BITS'(k));
    end
  end

  swm_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .start_i   (start_vec),
    .sample_i  (in_word_i.sample),
    .tok0_o    (tok0),
    .tok_vld_o (tok_vld)
  );

  // Hold the result word until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q.window_max  <= tok0.max;
      out_q.last_result <= last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  // At most one running maximum is ever in the chain
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vld))
    else $error("more than one running maximum in the chain");

  // A finished maximum only reaches cell zero while a word is being worked
  a_tok_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok0.vld |-> (state_q == ST_RUN))
    else $error("maximum at cell zero outside the walk");

  // The fill count never passes the chain length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_BITS'(MAX_WINDOW))
    else $error("fill count beyond chain length");

  // A blocked result word keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_stall_i |=> out_vld_q && $stable(out_q))
    else $error("stalled result word changed");

endmodule

// ----- tb/tb_sliding_window_maximum.sv -----
// Self-checking testbench for the sliding window maximum filter.
`timescale 1ns / 1ps

module tb_sliding_window_maximum;
  import swm_pkg::*;

  localparam int RANDOM_ITEMS = 1150;
  localparam int DRAIN_CYCLES = MAX_WINDOW + 8;
  localparam int HOLD_CYCLES  = 400;
  localparam int QUIET_LIMIT  = 2000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  in_word_t            in_word_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  out_word_t           out_word_o;
  logic                cfg_we_i    = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata_i = '0;

  // Words waiting to be sent and results still owed by the block
  in_word_t  sample_q[$];
  out_word_t max_q[$];

  // Shadow copy of the filter state
  sample_t             hist_mem[MAX_WINDOW];
  int                  fill_cnt  = 0;
  int                  wr_slot   = 0;
  logic [CFG_BITS-1:0] win_cfg   = CFG_RESET;

  // Idle controls, owned by the stimulus process
  bit in_gaps_on   = 1'b0;
  bit out_stalls_on = 1'b0;
  bit hold_req     = 1'b0;

  int fail_cnt = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_seen = 1'b0;
  int quiet_cnt = 0;
  int stall_pick;

  sliding_window_maximum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic int eff_window(input logic [CFG_BITS-1:0] size);
    if (size == 0) return 1;
    if (size > MAX_WINDOW) return MAX_WINDOW;
    return int'(size);
  endfunction

  // Store the word in the history and queue the window maximum it yields
  function automatic void track_window_max(input in_word_t word);
    int        span;
    int        idx;
    sample_t   best;
    out_word_t res;
    span = eff_window(win_cfg);
    hist_mem[wr_slot] = word.sample;
    wr_slot = (wr_slot + 1) % MAX_WINDOW;
    if (fill_cnt < MAX_WINDOW) fill_cnt++;
    if (fill_cnt >= span) begin
      best = hist_mem[(wr_slot + MAX_WINDOW - 1) % MAX_WINDOW];
      for (int j = 1; j < span; j++) begin
        idx = (wr_slot + MAX_WINDOW - 1 - j) % MAX_WINDOW;
        if (hist_mem[idx] > best) best = hist_mem[idx];
      end
      res.window_max  = best;
      res.last_result = word.last_sample;
      max_q = {max_q, res};
    end
    if (word.last_sample) begin
      fill_cnt = 0;
      wr_slot  = 0;
    end
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Sender: predict on each accepted word, then load the next one
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) track_window_max(in_word_i);
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_q.size() != 0) begin
          in_word_i  <= sample_q.pop_front();
          in_valid_i <= 1'b1;
          if (in_gaps_on) gap_left = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted result, then pick the next stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen = hold_req;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (max_q.size() == 0) begin
          $error("window_max: no result expected, got %0d", out_word_o.window_max);
          fail_cnt++;
        end else begin
          if (out_word_o.window_max !== max_q[0].window_max) begin
            $error("window_max: expected %0d, got %0d",
                   max_q[0].window_max, out_word_o.window_max);
            fail_cnt++;
          end
          if (out_word_o.last_result !== max_q[0].last_result) begin
            $error("last_result: expected %0b, got %0b",
                   max_q[0].last_result, out_word_o.last_result);
            fail_cnt++;
          end
          void'(max_q.pop_front());
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!out_stalls_on) begin
        out_stall_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 70) begin
          out_stall_i <= 1'b0;
        end else if (stall_pick < 96) begin
          stall_left = $urandom_range(0, 3);
          out_stall_i <= 1'b1;
        end else begin
          stall_left = $urandom_range(15, 60);
          out_stall_i <= 1'b1;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
    begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
      if (quiet_cnt == QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_window(input int size);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= size[CFG_BITS-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    win_cfg  = size[CFG_BITS-1:0];
  endtask

  task automatic push_word(input sample_t value, input bit last);
    in_word_t word;
    word.sample      = value;
    word.last_sample = last;
    sample_q = {sample_q, word};
  endtask

  // Hold until everything sent has come back and the block has gone quiet
  task automatic drain();
    @(negedge clk_i);
    while (sample_q.size() != 0 || in_valid_i || max_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2, 3, 4: return sample_t'($urandom_range(0, 8)) - 4;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Queue n words as sequences of random length; the last one may stay open
  task automatic queue_sequences(input int n);
    int span;
    int len;
    int r;
    int left;
    span = eff_window(win_cfg);
    left = n;
    while (left > 0) begin
      r = $urandom_range(0, 9);
      if (r < 8) len = $urandom_range(span, 3 * span + 4);
      else if (r < 9) len = $urandom_range(1, span);
      else len = $urandom_range(1, 3);
      for (int k = 0; k < len && left > 0; k++) begin
        push_word(rand_sample(), k == len - 1);
        left--;
      end
    end
  endtask

  initial begin
    int sent;
    int size;
    int n;
    int r;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words with the reset window of three
    push_word(32'sh8000_0000, 1'b0);
    push_word(-1, 1'b0);
    push_word(0, 1'b0);
    push_word(1, 1'b0);
    push_word(32'sh7fff_ffff, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(32'sh8000_0000, 1'b0);
    push_word(5, 1'b0);
    push_word(5, 1'b0);
    push_word(5, 1'b1);
    push_word(9, 1'b1);
    push_word(-7, 1'b0);
    push_word(-7, 1'b1);
    push_word(-3, 1'b0);
    push_word(-8, 1'b0);
    push_word(-2, 1'b0);
    push_word(32'sh5555_5555, 1'b0);
    push_word(32'shaaaa_aaaa, 1'b0);
    push_word(32'sh7fff_ffff, 1'b1);
    push_word(10, 1'b0);
    push_word(20, 1'b0);
    drain();

    // Shrink the window to zero in the middle of a sequence
    write_window(0);
    push_word(4, 1'b0);
    push_word(30, 1'b1);
    drain();

    // Long receiver hold while the sender keeps offering words
    write_window(4);
    hold_req = ~hold_req;
    queue_sequences(200);
    drain();

    sent = 0;
    n = 0;
    while (sent < RANDOM_ITEMS) begin
      case (n)
        0: size = 127;
        1: size = 1;
        2: size = 64;
        3: size = 2;
        4: size = 65;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 70) size = $urandom_range(0, 12);
          else if (r < 85) size = $urandom_range(13, 63);
          else size = $urandom_range(64, 127);
        end
      endcase
      write_window(size);
      r = $urandom_range(0, 9);
      in_gaps_on    = (r >= 2) && (r != 9);
      out_stalls_on = (r >= 2) && (r != 8);
      n++;
      if (eff_window(win_cfg) <= 12) r = $urandom_range(60, 140);
      else r = $urandom_range(20, 50);
      @(negedge clk_i);
      queue_sequences(r);
      sent += r;
      drain();
    end

    if (fail_cnt == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
design/swm_pkg.sv
design/swm_cell.sv
design/swm_chain.sv
design/sliding_window_maximum.sv
tb/tb_sliding_window_maximum.sv
